/* rtl/dcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared constants, types and helpers for the dominant channel colorizer.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;
  localparam int ALPHA_W    = 9;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FACTOR_W   = ALPHA_W + 1;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
  localparam logic [CH_W-1:0]    SAT_MAX     = CH_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pix_t;

  typedef enum logic [1:0] {
    WIN_RED,
    WIN_GREEN,
    WIN_BLUE
  } win_t;

  typedef struct packed {
    pix_t pix;
    win_t win;
    logic border;
  } item_t;

  typedef struct packed {
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

/* rtl/dcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_ram
// Single-port RAM, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module dcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/dcc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_queue
// Small FIFO of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module dcc_queue
  import dcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head_item,
  output q_status_t status
);

  item_t             slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item         = slots_r[rd_ptr_r];
  assign status.head_valid = (count_r != '0);
  assign status.count      = count_r;

endmodule

/* rtl/dcc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_front
// Accepts pixels, tracks raster position, reads the row above and picks
// the dominant channel of the 2x2 window.
// ----------------------------------------------------------------------------
module dcc_front
  import dcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pix_t               in_pix,
  input  logic               in_frame_start,
  input  logic [WIDTH_W-1:0] image_width,
  input  q_status_t          q_stat,
  output logic               push,
  output item_t              push_item
);

  logic               accept;
  logic [WIDTH_W-1:0] eff_width;
  logic [COL_W-1:0]   col;
  logic               first_row;
  logic [COL_W:0]     col_inc;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               first_row_r, first_row_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  pix_t               s1_pix_r;
  logic               s1_border_r;
  pix_t               left_r;
  pix_t               upleft_r;
  pix_t               up_pix;

  logic [CH_W-1:0]    max_r, max_g, max_b;
  win_t               win;

  function automatic logic [CH_W-1:0] max4(
    input logic [CH_W-1:0] a,
    input logic [CH_W-1:0] b,
    input logic [CH_W-1:0] c,
    input logic [CH_W-1:0] d
  );
    logic [CH_W-1:0] ab;
    logic [CH_W-1:0] cd;
    ab = (a > b) ? a : b;
    cd = (c > d) ? c : d;
    return (ab > cd) ? ab : cd;
  endfunction

  // room for the item in the classify stage and the new one
  assign in_ready = (q_stat.count + QCNT_W'(s1_valid_r)) < QCNT_W'(QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (image_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end

    col       = in_frame_start ? '0 : col_r;
    first_row = in_frame_start ? 1'b1 : first_row_r;
    col_inc   = {1'b0, col} + (COL_W + 1)'(1);

    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      if (WIDTH_W'(col_inc) >= eff_width) begin
        col_nxt       = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_nxt       = col_inc[COL_W-1:0];
        first_row_nxt = first_row;
      end
    end
    s1_valid_nxt = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      s1_valid_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= in_pix;
      s1_border_r <= first_row || (col == '0);
    end
    if (s1_valid_r) begin
      left_r   <= s1_pix_r;
      upleft_r <= up_pix;
    end
  end

  // read-before-write: each pixel sees the row above, then replaces it
  dcc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .en    (accept),
    .we    (accept),
    .addr  (col),
    .wdata (in_pix),
    .rdata (up_pix)
  );

  always_comb begin
    max_r = max4(s1_pix_r.r, left_r.r, up_pix.r, upleft_r.r);
    max_g = max4(s1_pix_r.g, left_r.g, up_pix.g, upleft_r.g);
    max_b = max4(s1_pix_r.b, left_r.b, up_pix.b, upleft_r.b);
    if (max_r >= max_g && max_r >= max_b) begin
      win = WIN_RED;
    end else if (max_g >= max_b) begin
      win = WIN_GREEN;
    end else begin
      win = WIN_BLUE;
    end
  end

  assign push             = s1_valid_r;
  assign push_item.pix    = s1_pix_r;
  assign push_item.win    = win;
  assign push_item.border = s1_border_r;

endmodule

/* rtl/dcc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_back
// Scales each channel by 1+alpha or 1-alpha, saturates, zeroes border pixels,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module dcc_back
  import dcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ALPHA_W-1:0] alpha,
  input  q_status_t          q_stat,
  input  item_t              head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pix_t               out_pix,
  output logic               out_border
);

  logic [ALPHA_W-1:0]  alpha_eff;
  logic [FACTOR_W-1:0] f_hi, f_lo;
  logic [FACTOR_W-1:0] f_r, f_g, f_b;
  pix_t                scaled;
  logic                out_valid_r, out_valid_nxt;
  pix_t                out_pix_r;
  logic                out_border_r;

  function automatic logic [CH_W-1:0] scale_sat(
    input logic [CH_W-1:0]     v,
    input logic [FACTOR_W-1:0] f
  );
    logic [CH_W+FACTOR_W-1:0] prod;
    logic [FACTOR_W-1:0]      shifted;
    prod    = (CH_W + FACTOR_W)'(v) * (CH_W + FACTOR_W)'(f);
    shifted = prod[CH_W+FACTOR_W-1:CH_W];
    return (shifted < FACTOR_W'(SAT_MAX)) ? shifted[CH_W-1:0] : SAT_MAX;
  endfunction

  assign pop = q_stat.head_valid && (!out_valid_r || out_ready);

  always_comb begin
    alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    f_hi      = FACTOR_W'(ALPHA_ONE) + FACTOR_W'(alpha_eff);
    f_lo      = FACTOR_W'(ALPHA_ONE) - FACTOR_W'(alpha_eff);
    f_r = f_lo;
    f_g = f_lo;
    f_b = f_lo;
    unique case (head_item.win)
      WIN_RED:   f_r = f_hi;
      WIN_GREEN: f_g = f_hi;
      WIN_BLUE:  f_b = f_hi;
      default:   f_b = f_hi;
    endcase
    if (head_item.border) begin
      scaled = '0;
    end else begin
      scaled.r = scale_sat(head_item.pix.r, f_r);
      scaled.g = scale_sat(head_item.pix.g, f_g);
      scaled.b = scale_sat(head_item.pix.b, f_b);
    end
    out_valid_nxt = pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pix_r    <= scaled;
      out_border_r <= head_item.border;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pix    = out_pix_r;
  assign out_border = out_border_r;

endmodule

/* rtl/dominant_channel_colorize.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominant_channel_colorize
// Emphasizes the channel that dominates each pixel's 2x2 neighborhood.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_ready    | in_blue_in, in_green_in, in_red_in,
//           |                        | in_frame_start
//   out     | out_valid / out_ready  | out_blue_out, out_green_out,
//           |                        | out_red_out, out_border_pixel
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// One pixel per clock sustained while out_ready stays high; an input transfer
// passes the classify stage, which holds the registered row-RAM read, then waits
// at the queue head before the output register loads.
// No clearing pass after reset: the row store is read for every pixel, but its
// data only matters for pixels below the first row, after it has been written.
// A four-entry queue between classify and scaling absorbs output stalls;
// in_ready drops once the queue and the classify stage together hold four items.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module dominant_channel_colorize
  import dcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       in_blue_in,
  input  logic [CH_W-1:0]       in_green_in,
  input  logic [CH_W-1:0]       in_red_in,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_blue_out,
  output logic [CH_W-1:0]       out_green_out,
  output logic [CH_W-1:0]       out_red_out,
  output logic                  out_border_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [WIDTH_W-1:0] width_r, width_nxt;
  pix_t               in_pix;
  pix_t               out_pix;
  q_status_t          q_stat;
  logic               push;
  item_t              push_item;
  logic               pop;
  item_t              head_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    alpha_nxt = alpha_r;
    width_nxt = width_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA: alpha_nxt = cfg_wdata[ALPHA_W-1:0];
        REG_WIDTH: width_nxt = cfg_wdata[WIDTH_W-1:0];
        default:   alpha_nxt = alpha_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      width_r <= WIDTH_RESET;
    end else begin
      alpha_r <= alpha_nxt;
      width_r <= width_nxt;
    end
  end

  assign in_pix.r = in_red_in;
  assign in_pix.g = in_green_in;
  assign in_pix.b = in_blue_in;

  dcc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pix         (in_pix),
    .in_frame_start (in_frame_start),
    .image_width    (width_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  dcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_stat)
  );

  dcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha      (alpha_r),
    .q_stat     (q_stat),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pix    (out_pix),
    .out_border (out_border_pixel)
  );

  assign out_red_out   = out_pix.r;
  assign out_green_out = out_pix.g;
  assign out_blue_out  = out_pix.b;

endmodule

/* rtl/dcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_checker
// Port-level checks for the dominant channel colorizer, bound to the top.
// ----------------------------------------------------------------------------
module dcc_checker
  import dcc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_blue_out,
  input logic [CH_W-1:0] out_green_out,
  input logic [CH_W-1:0] out_red_out,
  input logic            out_border_pixel
);

  // a held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_border_pixel))
    else $error("result changed while stalled");

  // border pixels carry all-zero data
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_border_pixel |->
      out_red_out == '0 && out_green_out == '0 && out_blue_out == '0)
    else $error("border pixel carries nonzero data");

  // nothing comes out right after reset, before any input transfer
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // after reset the pipeline is empty, so input is taken at once
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind dominant_channel_colorize dcc_checker u_dcc_checker (.*);
